// ===== hdl/matrix2x2_power_core_macros.svh =====
// Assertion helpers for the checker file m2p_checker.sv.
`ifndef MATRIX2X2_POWER_CORE_MACROS_SVH
`define MATRIX2X2_POWER_CORE_MACROS_SVH

// Check the consequent in the cycle after the antecedent.
`define M2P_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check the consequent after the given delay dly from the antecedent.
`define M2P_ASSERT_AFTER(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== hdl/m2p_pkg.sv =====
package m2p_pkg;

    localparam int WORD_W = 32;
    localparam int EXP_W  = 31;
    localparam int IN_W   = 160;
    localparam int OUT_W  = 128;

    typedef logic [WORD_W-1:0] t_word;

    // Matrix entries, m11 in the lowest bits.
    typedef struct packed {
        t_word m22;
        t_word m21;
        t_word m12;
        t_word m11;
    } t_mat;

    // Request to the shared multiplier.
    typedef struct packed {
        logic  en;
        t_word a;
        t_word b;
    } t_mul_req;

    localparam t_mat IDENTITY = '{
        m22: WORD_W'(1),
        m21: WORD_W'(0),
        m12: WORD_W'(0),
        m11: WORD_W'(1)
    };

    // Select an entry by {row, column}.
    function automatic t_word pick(input t_mat m, input logic [1:0] idx);
        t_word v;
        unique case (idx)
            2'b00: v = m.m11;
            2'b01: v = m.m12;
            2'b10: v = m.m21;
            2'b11: v = m.m22;
            default: v = m.m11;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/m2p_mul.sv =====
module m2p_mul (
    input  logic              i_clk,
    input  m2p_pkg::t_mul_req i_req,
    output m2p_pkg::t_word    o_prod
);

    logic [2*m2p_pkg::WORD_W-1:0] w_full;
    m2p_pkg::t_word               r_prod;

    assign w_full = {{m2p_pkg::WORD_W{1'b0}}, i_req.a} * {{m2p_pkg::WORD_W{1'b0}}, i_req.b};

    // Keep the low word of the product, registered.
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= w_full[m2p_pkg::WORD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/matrix2x2_power_core.sv =====
// Raises a 2x2 matrix of 32-bit words to a 31-bit power by square and multiply,
// starting from the identity; every product and sum wraps modulo 2^32. One item is
// worked at a time and the input is not ready meanwhile. All arithmetic goes through
// one shared 32x32 multiplier feeding one adder, so each matrix product takes eight
// multiplies. Squaring stops as soon as no set exponent bit remains. The result sits
// in an output register, so a new matrix may be accepted while it waits.
module matrix2x2_power_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // a11 [31:0], a12 [63:32], a21 [95:64], a22 [127:96], power [158:128], zero [159]
    input  logic [159:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // r11 [31:0], r12 [63:32], r21 [95:64], r22 [127:96]
    output logic [127:0] o_m_axis_tdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MULA  = 3'd2;
    localparam logic [2:0] ST_SQR   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [3:0] CNT_ISSUE_END = 4'd8;
    localparam logic [3:0] CNT_COMMIT    = 4'd9;

    logic [2:0]                  r_state, n_state;
    logic [3:0]                  r_cnt, n_cnt;
    logic [m2p_pkg::EXP_W-1:0]   r_exp, n_exp;
    m2p_pkg::t_mat               r_acc, n_acc;
    m2p_pkg::t_mat               r_sq, n_sq;
    m2p_pkg::t_mat               r_tmp, n_tmp;
    m2p_pkg::t_word              r_half, n_half;
    m2p_pkg::t_mat               r_out, n_out;
    logic                        r_out_valid, n_out_valid;

    logic                        w_accept;
    logic                        w_busy;
    logic [2:0]                  w_k_issue;
    logic [2:0]                  w_k_done;
    logic                        w_done_valid;
    m2p_pkg::t_mat               w_left;
    m2p_pkg::t_mul_req           w_req;
    m2p_pkg::t_word              w_prod;
    m2p_pkg::t_word              w_sum;

    // Take no beat while reset is held.
    assign o_s_axis_tready = i_rst_n && (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_busy          = (r_state == ST_MULA) || (r_state == ST_SQR);

    // Issue product k: entry {i,j} = k[2:1], term t = k[0]; p[i][t] * sq[t][j].
    assign w_k_issue = r_cnt[2:0];
    assign w_left    = (r_state == ST_MULA) ? r_acc : r_sq;
    assign w_req.en  = w_busy && (r_cnt < CNT_ISSUE_END);
    assign w_req.a   = m2p_pkg::pick(w_left, {w_k_issue[2], w_k_issue[0]});
    assign w_req.b   = m2p_pkg::pick(r_sq, {w_k_issue[0], w_k_issue[1]});

    m2p_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    // The product issued in the previous cycle is on w_prod.
    assign w_k_done     = 3'(r_cnt - 4'd1);
    assign w_done_valid = w_busy && (r_cnt != 4'd0) && (r_cnt != CNT_COMMIT);
    assign w_sum        = r_half + w_prod;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_exp       = r_exp;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_tmp       = r_tmp;
        n_half      = r_half;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // Drop the result once the beat is taken.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_sq.m11 = i_s_axis_tdata[31:0];
                    n_sq.m12 = i_s_axis_tdata[63:32];
                    n_sq.m21 = i_s_axis_tdata[95:64];
                    n_sq.m22 = i_s_axis_tdata[127:96];
                    n_exp    = i_s_axis_tdata[158:128];
                    n_acc    = m2p_pkg::IDENTITY;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_cnt = 4'd0;
                priority if (r_exp == '0) begin
                    n_state = ST_OUT;
                end else if (r_exp[0]) begin
                    n_state = ST_MULA;
                end else begin
                    n_state = ST_SQR;
                end
            end
            ST_MULA, ST_SQR: begin
                n_cnt = r_cnt + 4'd1;
                // Pair up the two terms of each entry.
                if (w_done_valid) begin
                    if (!w_k_done[0]) begin
                        n_half = w_prod;
                    end else begin
                        unique case (w_k_done[2:1])
                            2'b00: n_tmp.m11 = w_sum;
                            2'b01: n_tmp.m12 = w_sum;
                            2'b10: n_tmp.m21 = w_sum;
                            2'b11: n_tmp.m22 = w_sum;
                            default: n_tmp.m11 = w_sum;
                        endcase
                    end
                end
                // Commit the finished product.
                if (r_cnt == CNT_COMMIT) begin
                    if (r_state == ST_MULA) begin
                        n_acc    = r_tmp;
                        n_exp[0] = 1'b0;
                    end else begin
                        n_sq  = r_tmp;
                        n_exp = r_exp >> 1;
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_exp  <= n_exp;
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_tmp  <= n_tmp;
        r_half <= n_half;
        r_out  <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

endmodule

// ===== hdl/m2p_checker.sv =====
`include "matrix2x2_power_core_macros.svh"

module m2p_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [159:0] i_s_axis_tdata,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [127:0] o_m_axis_tdata
);

    logic w_accept;
    logic w_idle_out;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_idle_out = w_accept && !o_m_axis_tvalid;

    // One matrix at a time: ready drops after each accepted beat.
    `M2P_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_s_axis_tready, "ready after accept")

    // A stalled result holds.
    `M2P_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // Zero power gives the identity.
    `M2P_ASSERT_AFTER(a_power_zero, i_clk, i_rst_n, w_idle_out && (i_s_axis_tdata[158:128] == 31'd0), 3, o_m_axis_tvalid && (o_m_axis_tdata[31:0] == 32'd1) && (o_m_axis_tdata[95:32] == 64'd0) && (o_m_axis_tdata[127:96] == 32'd1), "zero power not identity")

    // Power one returns the matrix itself after one product.
    `M2P_ASSERT_AFTER(a_power_one, i_clk, i_rst_n, w_idle_out && (i_s_axis_tdata[158:128] == 31'd1), 14, o_m_axis_tvalid && (o_m_axis_tdata == $past(i_s_axis_tdata[127:0], 14)), "power one mismatch")

endmodule

bind matrix2x2_power_core m2p_checker u_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int    CLK_HALF      = 2;
    localparam int    RESET_CYCLES  = 5;
    localparam int    RANDOM_ITEMS  = 1960;
    localparam int    DRAIN_CYCLES  = 700;
    localparam int    HOLD_CYCLES   = 3000;
    localparam int    STALL_LIMIT   = 20000;
    localparam int    PRINT_LIMIT   = 50;
    localparam int    PAD_W         = m2p_pkg::OUT_W - m2p_pkg::WORD_W;
    localparam m2p_pkg::t_word WORD_MIN     = 32'h8000_0000;
    localparam m2p_pkg::t_word WORD_MAX     = 32'h7FFF_FFFF;
    localparam m2p_pkg::t_word WORD_NEG_ONE = 32'hFFFF_FFFF;
    localparam logic [m2p_pkg::EXP_W-1:0] EXP_MAX = '1;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_s_axis_tvalid;
    logic                        o_s_axis_tready;
    logic [m2p_pkg::IN_W-1:0]    i_s_axis_tdata;
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready;
    logic [m2p_pkg::OUT_W-1:0]   o_m_axis_tdata;

    // Expected result matrices, oldest first
    m2p_pkg::t_mat expected_powers[$];
    int   mismatch_count;
    int   quiet_cycles;
    bit   no_idle;
    bit   hold_request;
    int   hold_left;
    int   stall_left;

    matrix2x2_power_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // 2x2 product, every multiply and add wrapping at 32 bits
    function automatic m2p_pkg::t_mat matrix_product(input m2p_pkg::t_mat p,
                                                     input m2p_pkg::t_mat q);
        m2p_pkg::t_mat r;
        r.m11 = p.m11 * q.m11 + p.m12 * q.m21;
        r.m12 = p.m11 * q.m12 + p.m12 * q.m22;
        r.m21 = p.m21 * q.m11 + p.m22 * q.m21;
        r.m22 = p.m21 * q.m12 + p.m22 * q.m22;
        return r;
    endfunction

    // Square and multiply from the identity, lowest exponent bit first
    function automatic m2p_pkg::t_mat matrix_power(input m2p_pkg::t_mat base,
                                                   input logic [m2p_pkg::EXP_W-1:0] e);
        m2p_pkg::t_mat acc;
        m2p_pkg::t_mat sq;
        acc = '{m22: 32'd1, m21: 32'd0, m12: 32'd0, m11: 32'd1};
        sq  = base;
        for (int i = 0; i < m2p_pkg::EXP_W; i++) begin
            if (e[i])
                acc = matrix_product(acc, sq);
            sq = matrix_product(sq, sq);
        end
        return acc;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 300);
    endfunction

    function automatic m2p_pkg::t_word rand_entry(input int mode);
        m2p_pkg::t_word w;
        case (mode)
            0: w = m2p_pkg::t_word'($urandom_range(0, 6)) - 32'd3;
            1: w = $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0: w = 32'd0;
                    1: w = 32'd1;
                    2: w = WORD_NEG_ONE;
                    3: w = WORD_MIN;
                    4: w = WORD_MAX;
                    default: w = $urandom;
                endcase
            end
        endcase
        return w;
    endfunction

    function automatic m2p_pkg::t_mat mat_of(input m2p_pkg::t_word a11,
                                             input m2p_pkg::t_word a12,
                                             input m2p_pkg::t_word a21,
                                             input m2p_pkg::t_word a22);
        m2p_pkg::t_mat m;
        m.m11 = a11;
        m.m12 = a12;
        m.m21 = a21;
        m.m22 = a22;
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [m2p_pkg::OUT_W-1:0] got,
                                   input logic [m2p_pkg::OUT_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    // Offer one beat, hold it until taken, log its expected power. Enter and leave on
    // a falling edge; valid stays high on return so a back-to-back beat needs no toggle.
    task automatic send_matrix(input m2p_pkg::t_mat base,
                               input logic [m2p_pkg::EXP_W-1:0] e);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, e, base};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_powers.push_back(matrix_power(base, e));
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every expected result is back
    task automatic wait_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_powers.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_zero_power();
        send_matrix(mat_of($urandom, $urandom, $urandom, $urandom), '0);
        send_matrix(mat_of(32'd0, 32'd0, 32'd0, 32'd0), '0);
        send_matrix(mat_of(WORD_NEG_ONE, WORD_NEG_ONE, WORD_NEG_ONE, WORD_NEG_ONE), '0);
        send_matrix(mat_of(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX), '0);
        wait_results();
    endtask

    task automatic test_extremes();
        send_matrix(mat_of(32'd1, 32'd0, 32'd0, 32'd1), EXP_MAX);
        send_matrix(mat_of(32'd0, 32'd0, 32'd0, 32'd0), 31'd1);
        send_matrix(mat_of(32'd2, 32'd3, 32'd5, 32'd7), 31'd1);
        send_matrix(mat_of(32'd2, 32'd3, 32'd5, 32'd7), 31'd2);
        send_matrix(mat_of(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN), EXP_MAX);
        send_matrix(mat_of(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX), EXP_MAX);
        send_matrix(mat_of(WORD_NEG_ONE, WORD_NEG_ONE, WORD_NEG_ONE, WORD_NEG_ONE), EXP_MAX);
        send_matrix(mat_of($urandom, $urandom, $urandom, $urandom), 31'h4000_0000);
        send_matrix(mat_of($urandom, $urandom, $urandom, $urandom), 31'h5555_5555);
        send_matrix(mat_of($urandom, $urandom, $urandom, $urandom), 31'h2AAA_AAAA);
        wait_results();
    endtask

    // Fibonacci matrix: fits at 46, wraps from 47 on
    task automatic test_overflow();
        send_matrix(mat_of(32'd1, 32'd1, 32'd1, 32'd0), 31'd46);
        send_matrix(mat_of(32'd1, 32'd1, 32'd1, 32'd0), 31'd47);
        send_matrix(mat_of(32'd1, 32'd1, 32'd1, 32'd0), 31'd1000);
        send_matrix(mat_of(WORD_MAX, 32'd1, WORD_NEG_ONE, WORD_MIN), 31'd3);
        send_matrix(mat_of(32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000), 31'd2);
        wait_results();
    endtask

    // Receiver holds off long while the sender keeps offering back to back
    task automatic test_backpressure();
        @(posedge i_clk);
        hold_request = 1'b1;
        no_idle      = 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < 6; i++)
            send_matrix(mat_of(rand_entry(1), rand_entry(1), rand_entry(1), rand_entry(1)),
                        31'($urandom_range(0, 255)));
        no_idle = 1'b0;
        wait_results();
    endtask

    task automatic test_random();
        int               mode;
        int               len;
        logic [31:0]      e;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Switch between idle-free stretches and ragged traffic
            if (n % 200 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            // Sender pauses until the block has returned everything
            if (n % 250 == 249)
                wait_results();
            mode = $urandom_range(0, 4);
            len  = $urandom_range(0, m2p_pkg::EXP_W);
            e    = $urandom & ((32'd1 << len) - 32'd1);
            if (len > 0 && $urandom_range(0, 1))
                e[len-1] = 1'b1;
            if (mode >= 3)
                mode = 2;
            else if (mode == 2)
                mode = 1;
            send_matrix(mat_of(rand_entry(mode), rand_entry(mode), rand_entry(mode),
                               rand_entry(mode)), e[m2p_pkg::EXP_W-1:0]);
        end
        no_idle = 1'b0;
        wait_results();
    endtask

    // Result side ready: random stalls, an occasional long hold-off
    initial begin
        i_m_axis_tready = 1'b0;
        hold_left       = 0;
        stall_left      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (no_idle) begin
                i_m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = gap_len();
            end
        end
    end

    // Compare each result beat with the oldest expected power
    always @(posedge i_clk) begin
        m2p_pkg::t_mat got;
        m2p_pkg::t_mat want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = m2p_pkg::t_mat'(o_m_axis_tdata);
            if (expected_powers.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata, '0);
            end else begin
                want = expected_powers.pop_front();
                if (got.m11 !== want.m11)
                    report_mismatch("r11", {{PAD_W{1'b0}}, got.m11}, {{PAD_W{1'b0}}, want.m11});
                if (got.m12 !== want.m12)
                    report_mismatch("r12", {{PAD_W{1'b0}}, got.m12}, {{PAD_W{1'b0}}, want.m12});
                if (got.m21 !== want.m21)
                    report_mismatch("r21", {{PAD_W{1'b0}}, got.m21}, {{PAD_W{1'b0}}, want.m21});
                if (got.m22 !== want.m22)
                    report_mismatch("r22", {{PAD_W{1'b0}}, got.m22}, {{PAD_W{1'b0}}, want.m22});
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        no_idle         = 1'b0;
        hold_request    = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_zero_power();
        test_extremes();
        test_overflow();
        test_backpressure();
        test_random();

        // Let any stray beat show up before the verdict
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/m2p_pkg.sv
hdl/m2p_mul.sv
hdl/matrix2x2_power_core.sv
hdl/m2p_checker.sv
sim/tb_top.sv
